// File: src/udpcls_pkg.sv
// Shared types, codes and constants of the UDP/IPv4 port classifier.
package udpcls_pkg;

  // Default for the longest frame that is still counted in full
  localparam int unsigned MAX_FRAME_DEF = 2048;

  // Frame layout
  localparam int unsigned ETH_HDR     = 14;
  localparam int unsigned UDP_HDR     = 8;
  localparam int unsigned ETYPE_HI_OFS = 12;
  localparam int unsigned ETYPE_LO_OFS = 13;
  localparam int unsigned PROTO_OFS   = 23;
  localparam int unsigned SRC_IP_OFS  = 26;
  localparam int unsigned SRC_IP_LEN  = 4;
  localparam int unsigned MIN_LEN     = 24;
  localparam int unsigned HDR_BASE    = ETH_HDR + UDP_HDR;

  localparam logic [23:0] ETH_IP_UDP  = 24'h080011;
  localparam logic [7:0]  ETYPE_HI    = ETH_IP_UDP[23:16];
  localparam logic [7:0]  ETYPE_LO    = ETH_IP_UDP[15:8];
  localparam logic [7:0]  PROTO_UDP   = ETH_IP_UDP[7:0];
  localparam logic [7:0]  IHL_MASK    = 8'h0F;

  localparam int unsigned NUM_PORTS   = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHRED        = 3'd0,
    CFG_QUIC_TX      = 3'd1,
    CFG_PLAIN_TX     = 3'd2,
    CFG_GOSSIP       = 3'd3,
    CFG_REPAIR_IN    = 3'd4,
    CFG_REPAIR_SERVE = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_UDP   = 3'd1,
    ST_UNDERSIZE = 3'd2,
    ST_NO_PORT   = 3'd3,
    ST_OVERSIZE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CL_SHRED    = 3'd0,
    CL_QUIC_TX  = 3'd1,
    CL_PLAIN_TX = 3'd2,
    CL_GOSSIP   = 3'd3,
    CL_REPAIR   = 3'd4
  } class_e;

  // Class selected by each configured port, in priority order
  localparam class_e PORT_CLASS [NUM_PORTS] = '{
    CL_SHRED, CL_QUIC_TX, CL_PLAIN_TX, CL_GOSSIP, CL_REPAIR, CL_REPAIR
  };

endpackage

// File: src/udp_ipv4_port_classifier_core.sv
// Top level of the UDP/IPv4 destination port classifier.
//
// Takes an Ethernet frame one byte per request and returns one result request
// on the byte marked last. A byte is registered on entry, runs through the
// header parse in the next cycle and, if it closes the frame, lands in the
// result register, so a frame's result passes the entry and then the result
// register on its way out. One byte is taken every cycle; the block holds input
// only when a last byte is waiting while the previous result is still stalled
// at the output. Parsing checks EtherType 0x0800 and protocol 17, takes the IHL
// from byte 14, places the UDP header at 14 + 4*IHL and captures the source
// address (byte 26 in bits 7:0), source port and destination port. The
// destination port is matched against six configured ports in index order;
// the first hit sets the class. Configuration writes are meant for idle
// periods and apply to frames that end after them.
module udp_ipv4_port_classifier_core #(
  parameter int unsigned MAX_FRAME = udpcls_pkg::MAX_FRAME_DEF,
  localparam int unsigned LEN_W    = $clog2(MAX_FRAME + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [udpcls_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [udpcls_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // byte input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [2:0]                        dest_class_o,
  output logic [31:0]                       src_ip_o,
  output logic [15:0]                       src_port_o,
  output logic [15:0]                       dst_port_o,
  output logic [6:0]                        header_len_o,
  output logic [LEN_W-1:0]                  frame_len_o
);
  import udpcls_pkg::*;

  // byte position saturates one past the limit
  localparam int unsigned POS_W = $clog2(MAX_FRAME + 2);

  // configuration
  logic [15:0] cfg_port_q [NUM_PORTS];

  // entry register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // per-frame parse state
  logic [POS_W-1:0] pos_q, pos_d;
  logic             match_q, match_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [31:0]      ip_q, ip_d;
  logic [15:0]      sport_q, sport_d;
  logic [15:0]      dport_q, dport_d;

  // result register
  logic             out_valid_q;
  status_e          status_q, status_d;
  class_e           class_q, class_d;
  logic [31:0]      ip_out_q;
  logic [15:0]      sport_out_q;
  logic [15:0]      dport_out_q;
  logic [6:0]       hlen_q, hlen_d;
  logic [LEN_W-1:0] flen_q, flen_d;

  logic             s1_fire, in_fire, frame_end;
  logic [6:0]       udp_pos;
  logic [POS_W-1:0] pos_nx;
  logic             over;
  logic [1:0]       ip_lane;
  logic             hit;
  class_e           hit_class;

  // Hold a last byte only while the previous result is still stuck
  assign s1_fire    = s1_valid_q && !(s1_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign frame_end  = s1_fire && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        cfg_port_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHRED:        cfg_port_q[0] <= cfg_data_i;
        CFG_QUIC_TX:      cfg_port_q[1] <= cfg_data_i;
        CFG_PLAIN_TX:     cfg_port_q[2] <= cfg_data_i;
        CFG_GOSSIP:       cfg_port_q[3] <= cfg_data_i;
        CFG_REPAIR_IN:    cfg_port_q[4] <= cfg_data_i;
        CFG_REPAIR_SERVE: cfg_port_q[5] <= cfg_data_i;
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  // Entry register: take a byte whenever the stage is free or moving on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Header parse for the byte in the entry register
  always_comb begin
    ihl_d   = ihl_q;
    match_d = match_q;
    ip_d    = ip_q;
    sport_d = sport_q;
    dport_d = dport_q;

    // IHL is live on the byte that carries it
    if (pos_q == POS_W'(ETH_HDR)) begin
      ihl_d = s1_byte_q[3:0] & IHL_MASK[3:0];
    end
    udp_pos = 7'(ETH_HDR) + 7'({ihl_d, 2'b00});

    if ((pos_q == POS_W'(ETYPE_HI_OFS) && s1_byte_q != ETYPE_HI) ||
        (pos_q == POS_W'(ETYPE_LO_OFS) && s1_byte_q != ETYPE_LO) ||
        (pos_q == POS_W'(PROTO_OFS) && s1_byte_q != PROTO_UDP)) begin
      match_d = 1'b0;
    end

    // bytes 26..29 fill lanes 0..3 of the source address
    ip_lane = pos_q[1:0] - 2'(SRC_IP_OFS);
    if (pos_q >= POS_W'(SRC_IP_OFS) && pos_q < POS_W'(SRC_IP_OFS + SRC_IP_LEN)) begin
      ip_d = ip_q | (32'(s1_byte_q) << {ip_lane, 3'b000});
    end

    // port bytes, big-endian
    if (pos_q == POS_W'(udp_pos)) begin
      sport_d = {s1_byte_q, sport_q[7:0]};
    end else if (pos_q == POS_W'(udp_pos) + POS_W'(1)) begin
      sport_d = {sport_q[15:8], s1_byte_q};
    end else if (pos_q == POS_W'(udp_pos) + POS_W'(2)) begin
      dport_d = {s1_byte_q, dport_q[7:0]};
    end else if (pos_q == POS_W'(udp_pos) + POS_W'(3)) begin
      dport_d = {dport_q[15:8], s1_byte_q};
    end

    pos_nx = (pos_q != POS_W'(MAX_FRAME + 1)) ? pos_q + POS_W'(1) : pos_q;
    pos_d  = pos_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 1'b1;
      ihl_q   <= '0;
      ip_q    <= '0;
      sport_q <= '0;
      dport_q <= '0;
    end else if (frame_end) begin
      // Clear everything when the frame closes
      pos_q   <= '0;
      match_q <= 1'b1;
      ihl_q   <= '0;
      ip_q    <= '0;
      sport_q <= '0;
      dport_q <= '0;
    end else if (s1_fire) begin
      pos_q   <= pos_d;
      match_q <= match_d;
      ihl_q   <= ihl_d;
      ip_q    <= ip_d;
      sport_q <= sport_d;
      dport_q <= dport_d;
    end
  end

  // Result of the closing byte, built from the updated parse state
  always_comb begin
    over   = pos_nx > POS_W'(MAX_FRAME);
    flen_d = over ? LEN_W'(MAX_FRAME) : LEN_W'(pos_nx);
    hlen_d = 7'(HDR_BASE) + 7'({ihl_d, 2'b00});

    // Walk from lowest priority up so the first configured match wins
    hit       = 1'b0;
    hit_class = CL_SHRED;
    for (int i = NUM_PORTS - 1; i >= 0; i--) begin
      if (dport_d == cfg_port_q[i]) begin
        hit       = 1'b1;
        hit_class = PORT_CLASS[i];
      end
    end

    class_d = CL_SHRED;
    if (over) begin
      status_d = ST_OVERSIZE;
    end else if (flen_d < LEN_W'(MIN_LEN)) begin
      status_d = ST_UNDERSIZE;
    end else if (!match_d) begin
      status_d = ST_NOT_UDP;
    end else if (flen_d < LEN_W'(hlen_d)) begin
      status_d = ST_UNDERSIZE;
    end else if (!hit) begin
      status_d = ST_NO_PORT;
    end else begin
      status_d = ST_OK;
      class_d  = hit_class;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      status_q    <= status_d;
      class_q     <= class_d;
      ip_out_q    <= ip_d;
      sport_out_q <= sport_d;
      dport_out_q <= dport_d;
      hlen_q      <= hlen_d;
      flen_q      <= flen_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign dest_class_o = class_q;
  assign src_ip_o     = ip_out_q;
  assign src_port_o   = sport_out_q;
  assign dst_port_o   = dport_out_q;
  assign header_len_o = hlen_q;
  assign frame_len_o  = flen_q;

endmodule

// File: src/udpcls_checker.sv
// Port-level checks of the UDP/IPv4 port classifier, bound to its top level.
module udpcls_checker #(
  parameter int unsigned MAX_FRAME = udpcls_pkg::MAX_FRAME_DEF,
  localparam int unsigned LEN_W    = $clog2(MAX_FRAME + 1)
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [2:0]                        status_o,
  input logic [2:0]                        dest_class_o,
  input logic [31:0]                       src_ip_o,
  input logic [15:0]                       src_port_o,
  input logic [15:0]                       dst_port_o,
  input logic [6:0]                        header_len_o,
  input logic [LEN_W-1:0]                  frame_len_o
);
  import udpcls_pkg::*;

  // A stalled result keeps its request and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(dest_class_o) && $stable(src_ip_o) && $stable(src_port_o) &&
      $stable(dst_port_o) && $stable(header_len_o) && $stable(frame_len_o))
    else $error("stalled result changed");

  // Any failed frame reports the default class
  a_class_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> dest_class_o == CL_SHRED)
    else $error("class set on a failed frame");

  // Header length is 22 plus a multiple of four
  a_hlen_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> header_len_o >= 7'(HDR_BASE) && header_len_o[1:0] == 2'b10)
    else $error("malformed header length");

  // An accepted frame carries its whole header
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      frame_len_o >= LEN_W'(header_len_o) && frame_len_o >= LEN_W'(MIN_LEN))
    else $error("ok status on a short frame");

  // Oversize frames report the saturated length
  a_over_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OVERSIZE |-> frame_len_o == LEN_W'(MAX_FRAME))
    else $error("oversize frame length not saturated");

endmodule

bind udp_ipv4_port_classifier_core udpcls_checker #(.MAX_FRAME(MAX_FRAME)) u_udpcls_checker (.*);
